FILE: hdl/ethipf_pkg.sv
`default_nettype none

package ethipf_pkg;

    // Frame constants
    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // Header offsets in bytes from the start of the frame.
    localparam logic [6:0] POS_TYPE_LO  = 7'd13;
    localparam logic [6:0] POS_TYPE_END = 7'd14;
    localparam logic [6:0] POS_TAG_TYPE = 7'd16;
    localparam logic [6:0] POS_TAG_LO   = 7'd17;
    localparam logic [6:0] POS_TAG_END  = 7'd18;
    localparam logic [6:0] POS_MAX      = 7'd127;

    // Offsets inside the IPv4 header.
    localparam logic [6:0] IP_OFS_IHL   = 7'd0;
    localparam logic [6:0] IP_OFS_PROTO = 7'd9;
    localparam logic [6:0] IP_OFS_SRC   = 7'd12;
    localparam logic [6:0] IP_OFS_SRC_E = 7'd15;
    localparam logic [6:0] IP_OFS_DST_E = 7'd19;
    localparam logic [6:0] IP_OFS_END   = 7'd20;
    localparam logic [3:0] IHL_MIN      = 4'd5;

    // Reject reasons; zero also means no rejection recorded yet.
    typedef enum logic [2:0] {
        REASON_PASS  = 3'd0,
        REASON_MAC   = 3'd1,
        REASON_TYPE  = 3'd2,
        REASON_PROTO = 3'd3,
        REASON_IP    = 3'd4,
        REASON_PORT  = 3'd5,
        REASON_SHORT = 3'd6
    } t_reason;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MAC_DST_EN = 3'd0,
        CFG_MAC_SRC_EN = 3'd1,
        CFG_MAC_DST    = 3'd2,
        CFG_MAC_SRC    = 3'd3,
        CFG_IP_SRC     = 3'd4,
        CFG_IP_DST     = 3'd5,
        CFG_SPORT      = 3'd6,
        CFG_DPORT      = 3'd7
    } t_cfg_index;

    // Current match settings.
    typedef struct packed {
        logic        mac_dst_en;
        logic        mac_src_en;
        logic [47:0] mac_dst;
        logic [47:0] mac_src;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_cfg;

    // Verdict handed from the parser to the result register.
    typedef struct packed {
        logic    valid;
        logic    accept;
        t_reason reason;
    } t_verdict;

    // Status of the input stage, seen by the top level.
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage;

endpackage

`default_nettype wire

FILE: hdl/ethipf_cfg_regs.sv
`default_nettype none

module ethipf_cfg_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [47:0]       i_cfg_data,
    output ethipf_pkg::t_cfg       o_cfg
);

    ethipf_pkg::t_cfg r_cfg;

    // Register file, written one register per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (ethipf_pkg::t_cfg_index'(i_cfg_index))
                ethipf_pkg::CFG_MAC_DST_EN: r_cfg.mac_dst_en <= i_cfg_data[0];
                ethipf_pkg::CFG_MAC_SRC_EN: r_cfg.mac_src_en <= i_cfg_data[0];
                ethipf_pkg::CFG_MAC_DST:    r_cfg.mac_dst    <= i_cfg_data;
                ethipf_pkg::CFG_MAC_SRC:    r_cfg.mac_src    <= i_cfg_data;
                ethipf_pkg::CFG_IP_SRC:     r_cfg.ip_src     <= i_cfg_data[31:0];
                ethipf_pkg::CFG_IP_DST:     r_cfg.ip_dst     <= i_cfg_data[31:0];
                ethipf_pkg::CFG_SPORT:      r_cfg.sport      <= i_cfg_data[15:0];
                ethipf_pkg::CFG_DPORT:      r_cfg.dport      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/ethipf_parser.sv
`default_nettype none

module ethipf_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ethipf_pkg::t_cfg  i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    input  wire logic              i_out_free,
    output ethipf_pkg::t_verdict   o_verdict,
    output ethipf_pkg::t_stage     o_stage
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Per-frame parse state
    logic [6:0]         r_pos;
    logic               r_vlan;
    logic [15:0]        r_type_shift;
    logic [3:0]         r_hdr_words;
    logic [31:0]        r_field_shift;
    ethipf_pkg::t_reason r_reason;
    logic               r_ports_seen;

    logic [6:0]         n_pos;
    logic               n_vlan;
    logic [15:0]        n_type_shift;
    logic [3:0]         n_hdr_words;
    logic [31:0]        n_field_shift;
    ethipf_pkg::t_reason n_reason;
    logic               n_ports_seen;
    ethipf_pkg::t_reason n_final;

    logic       fire;
    logic [6:0] base;
    logic [6:0] rel;
    logic [7:0] mac_byte;

    // A byte leaves the input register unless it is a final byte facing a full result register.
    assign fire       = r_in_valid && (!r_in_last || i_out_free);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Expected MAC byte for the current position in either address field.
    always_comb begin
        case (r_pos)
            7'd0:    mac_byte = i_cfg.mac_dst[47:40];
            7'd1:    mac_byte = i_cfg.mac_dst[39:32];
            7'd2:    mac_byte = i_cfg.mac_dst[31:24];
            7'd3:    mac_byte = i_cfg.mac_dst[23:16];
            7'd4:    mac_byte = i_cfg.mac_dst[15:8];
            7'd5:    mac_byte = i_cfg.mac_dst[7:0];
            7'd6:    mac_byte = i_cfg.mac_src[47:40];
            7'd7:    mac_byte = i_cfg.mac_src[39:32];
            7'd8:    mac_byte = i_cfg.mac_src[31:24];
            7'd9:    mac_byte = i_cfg.mac_src[23:16];
            7'd10:   mac_byte = i_cfg.mac_src[15:8];
            default: mac_byte = i_cfg.mac_src[7:0];
        endcase
    end

    assign base = r_vlan ? ethipf_pkg::POS_TAG_END : ethipf_pkg::POS_TYPE_END;
    assign rel  = r_pos - base;

    // Parse the byte in the input register against the current position.
    always_comb begin
        n_pos         = (r_pos == ethipf_pkg::POS_MAX) ? r_pos : r_pos + 7'd1;
        n_vlan        = r_vlan;
        n_type_shift  = r_type_shift;
        n_hdr_words   = r_hdr_words;
        n_field_shift = r_field_shift;
        n_reason      = r_reason;
        n_ports_seen  = r_ports_seen;

        if (r_reason == ethipf_pkg::REASON_PASS) begin
            if (r_pos < 7'd6) begin
                if (i_cfg.mac_dst_en && (r_in_byte != mac_byte)) begin
                    n_reason = ethipf_pkg::REASON_MAC;
                end
            end else if (r_pos < 7'd12) begin
                if (i_cfg.mac_src_en && (r_in_byte != mac_byte)) begin
                    n_reason = ethipf_pkg::REASON_MAC;
                end
            end else if (r_pos < ethipf_pkg::POS_TYPE_END) begin
                n_type_shift = {r_type_shift[7:0], r_in_byte};
                if (r_pos == ethipf_pkg::POS_TYPE_LO) begin
                    if (n_type_shift == ethipf_pkg::TYPE_VLAN) begin
                        n_vlan = 1'b1;
                    end else if (n_type_shift != ethipf_pkg::TYPE_IPV4) begin
                        n_reason = ethipf_pkg::REASON_TYPE;
                    end
                end
            end else if (r_vlan && (r_pos < ethipf_pkg::POS_TAG_END)) begin
                // Tag control bytes are skipped; the inner EtherType follows.
                if (r_pos >= ethipf_pkg::POS_TAG_TYPE) begin
                    n_type_shift = {r_type_shift[7:0], r_in_byte};
                    if ((r_pos == ethipf_pkg::POS_TAG_LO) &&
                        (n_type_shift != ethipf_pkg::TYPE_IPV4)) begin
                        n_reason = ethipf_pkg::REASON_TYPE;
                    end
                end
            end else if (rel == ethipf_pkg::IP_OFS_IHL) begin
                n_hdr_words = r_in_byte[3:0];
                if (n_hdr_words < ethipf_pkg::IHL_MIN) begin
                    n_reason = ethipf_pkg::REASON_SHORT;
                end
            end else if (rel == ethipf_pkg::IP_OFS_PROTO) begin
                if ((r_in_byte != ethipf_pkg::PROTO_TCP) &&
                    (r_in_byte != ethipf_pkg::PROTO_UDP)) begin
                    n_reason = ethipf_pkg::REASON_PROTO;
                end
            end else if ((rel >= ethipf_pkg::IP_OFS_SRC) && (rel < ethipf_pkg::IP_OFS_END)) begin
                n_field_shift = {r_field_shift[23:0], r_in_byte};
                if ((rel == ethipf_pkg::IP_OFS_SRC_E) && (i_cfg.ip_src != 32'd0) &&
                    (n_field_shift != i_cfg.ip_src)) begin
                    n_reason = ethipf_pkg::REASON_IP;
                end
                if ((rel == ethipf_pkg::IP_OFS_DST_E) && (i_cfg.ip_dst != 32'd0) &&
                    (n_field_shift != i_cfg.ip_dst)) begin
                    n_reason = ethipf_pkg::REASON_IP;
                end
            end else if (rel[6:2] == {1'b0, r_hdr_words}) begin
                // Ports start at four times the header length in words.
                n_field_shift = {r_field_shift[23:0], r_in_byte};
                if ((rel[1:0] == 2'd1) && (i_cfg.sport != 16'd0) &&
                    (n_field_shift[15:0] != i_cfg.sport)) begin
                    n_reason = ethipf_pkg::REASON_PORT;
                end
                if (rel[1:0] == 2'd3) begin
                    if ((i_cfg.dport != 16'd0) &&
                        (n_field_shift[15:0] != i_cfg.dport)) begin
                        n_reason = ethipf_pkg::REASON_PORT;
                    end
                    n_ports_seen = 1'b1;
                end
            end
        end

        // Verdict for a final byte: a frame that never reached its ports is truncated.
        if (n_reason != ethipf_pkg::REASON_PASS) begin
            n_final = n_reason;
        end else if (n_ports_seen) begin
            n_final = ethipf_pkg::REASON_PASS;
        end else begin
            n_final = ethipf_pkg::REASON_SHORT;
        end
    end

    // State update; the final byte returns everything to the start of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in_last)) begin
            r_pos         <= '0;
            r_vlan        <= 1'b0;
            r_type_shift  <= '0;
            r_hdr_words   <= '0;
            r_field_shift <= '0;
            r_reason      <= ethipf_pkg::REASON_PASS;
            r_ports_seen  <= 1'b0;
        end else if (fire) begin
            r_pos         <= n_pos;
            r_vlan        <= n_vlan;
            r_type_shift  <= n_type_shift;
            r_hdr_words   <= n_hdr_words;
            r_field_shift <= n_field_shift;
            r_reason      <= n_reason;
            r_ports_seen  <= n_ports_seen;
        end
    end

    assign o_verdict.valid  = fire && r_in_last;
    assign o_verdict.accept = (n_final == ethipf_pkg::REASON_PASS);
    assign o_verdict.reason = n_final;

    assign o_stage.valid = r_in_valid;
    assign o_stage.last  = r_in_last;

endmodule

`default_nettype wire

FILE: hdl/ethipf_out_reg.sv
`default_nettype none

module ethipf_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ethipf_pkg::t_verdict i_verdict,
    output logic                      o_free,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_accept,
    output logic [2:0]                o_reject_reason
);

    logic       r_valid;
    logic       r_accept;
    logic [2:0] r_reason;

    // The register can take a verdict when empty or when its contents leave now.
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_verdict.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_verdict.valid) begin
            r_accept <= i_verdict.accept;
            r_reason <= i_verdict.reason;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_accept        = r_accept;
    assign o_reject_reason = r_reason;

endmodule

`default_nettype wire

FILE: hdl/ethernet_ipv4_header_filter_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_data_byte, i_last_byte
// result    out        o_out_valid / i_out_ready  o_accept, o_reject_reason
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle unless a final byte waits on a full result register;
// each byte is parsed from the input register, and a final byte's verdict is then
// registered in the result register.
// Reset is synchronous and active low; it clears all match registers and the frame state.
// A stalled result holds back a final byte, and the input with it; earlier bytes flow on.
`default_nettype none

module ethernet_ipv4_header_filter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_accept,
    output logic [2:0]       o_reject_reason
);

    ethipf_pkg::t_cfg     cfg;
    ethipf_pkg::t_verdict verdict;
    ethipf_pkg::t_stage   stage;
    logic                 out_free;

    ethipf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ethipf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_out_free  (out_free),
        .o_verdict   (verdict),
        .o_stage     (stage)
    );

    ethipf_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_verdict       (verdict),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accept        (o_accept),
        .o_reject_reason (o_reject_reason)
    );

    // A final byte must wait while the previous verdict is still held.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && stage.valid && stage.last) |-> !verdict.valid)
        else $error("final byte parsed while result register was full");

    // The accept flag agrees with the reason code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accept == (o_reject_reason == ethipf_pkg::REASON_PASS)))
        else $error("accept flag disagrees with reject reason");

    // A verdict only arises from a final byte in the input register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        verdict.valid |-> (stage.valid && stage.last))
        else $error("verdict without a final byte");

endmodule

`default_nettype wire
